// ===== rtl/esc_pkg.sv =====
// esc_pkg: shared types, constants and character decode for the expression syntax checker
// no dependencies; used by esc_cell, expression_syntax_checker and esc_checker

package esc_pkg;

  localparam int StackDepth = 64;
  localparam int CntW       = $clog2(StackDepth + 1);

  localparam logic [7:0] ChHash   = 8'h23;  // '#'
  localparam logic [7:0] ChDot    = 8'h2e;  // '.'
  localparam logic [7:0] ChParOpn = 8'h28;  // '('
  localparam logic [7:0] ChBrkOpn = 8'h5b;  // '['
  localparam logic [7:0] ChBrcOpn = 8'h7b;  // '{'
  localparam logic [7:0] ChParCls = 8'h29;  // ')'
  localparam logic [7:0] ChBrkCls = 8'h5d;  // ']'
  localparam logic [7:0] ChBrcCls = 8'h7d;  // '}'
  localparam logic [7:0] ChPlus   = 8'h2b;  // '+'
  localparam logic [7:0] ChMinus  = 8'h2d;  // '-'
  localparam logic [7:0] ChStar   = 8'h2a;  // '*'
  localparam logic [7:0] ChSlash  = 8'h2f;  // '/'
  localparam logic [7:0] ChCaret  = 8'h5e;  // '^'
  localparam logic [7:0] ChZero   = 8'h30;  // '0'
  localparam logic [7:0] ChNine   = 8'h39;  // '9'

  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_OP    = 3'd2,
    CLS_OPEN  = 3'd3,
    CLS_CLOSE = 3'd4,
    CLS_DOT   = 3'd5
  } cls_e;

  typedef enum logic [1:0] {
    KIND_PAR = 2'd0,
    KIND_BRK = 2'd1,
    KIND_BRC = 2'd2
  } kind_e;

  typedef struct packed {
    cls_e  cls;
    kind_e kind;
  } decode_t;

  // shift controls handed to every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

  function automatic decode_t classify(input logic [7:0] c);
    decode_t r;
    r.cls  = CLS_NONE;
    r.kind = KIND_PAR;
    if (c >= ChZero && c <= ChNine) begin
      r.cls = CLS_DIGIT;
    end else if (c == ChPlus || c == ChMinus || c == ChStar || c == ChSlash ||
                 c == ChCaret) begin
      r.cls = CLS_OP;
    end else if (c == ChParOpn) begin
      r.cls = CLS_OPEN;
    end else if (c == ChBrkOpn) begin
      r.cls  = CLS_OPEN;
      r.kind = KIND_BRK;
    end else if (c == ChBrcOpn) begin
      r.cls  = CLS_OPEN;
      r.kind = KIND_BRC;
    end else if (c == ChParCls) begin
      r.cls = CLS_CLOSE;
    end else if (c == ChBrkCls) begin
      r.cls  = CLS_CLOSE;
      r.kind = KIND_BRK;
    end else if (c == ChBrcCls) begin
      r.cls  = CLS_CLOSE;
      r.kind = KIND_BRC;
    end else if (c == ChDot) begin
      r.cls = CLS_DOT;
    end
    return r;
  endfunction

  function automatic logic allowed_after(input cls_e a, input cls_e b);
    logic ok;
    unique case (a)
      CLS_DIGIT: ok = (b == CLS_DIGIT) || (b == CLS_OP) || (b == CLS_CLOSE);
      CLS_OP:    ok = (b == CLS_DIGIT) || (b == CLS_OPEN);
      CLS_OPEN:  ok = (b == CLS_DIGIT) || (b == CLS_OPEN);
      CLS_CLOSE: ok = (b == CLS_OP) || (b == CLS_CLOSE);
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/expression_syntax_checker.sv =====
// expression_syntax_checker: streaming syntax check of '#'-terminated expressions
// depends on esc_pkg and esc_cell
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i, in_ready_o, ch_i, last_i  | sink
//  out     | out_valid_o, out_ready_i, valid_res_o | source
//
// one character per cycle while in_ready_o is high; the verdict shows in the cycle after the final character
// the bracket stack is a row of cells that all shift together on each push and pop
// the result sits in an output register; input is taken while it is free or being drained
// reset clears the control state; stack cell contents are never read before being written

module expression_syntax_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o
);

  localparam int Depth = esc_pkg::StackDepth;
  localparam int CntW  = esc_pkg::CntW;

  logic [CntW-1:0]       cnt_q, cnt_d;
  esc_pkg::cls_e         prev_cls_q, prev_cls_d;
  logic                  prev_dot_q, prev_dot_d;
  logic                  at_start_q, at_start_d;
  logic                  failed_q, failed_d;
  logic                  out_vld_q, out_vld_d;
  logic                  res_q, res_d;

  logic                  in_acc;
  esc_pkg::decode_t      dec;
  esc_pkg::stack_ctrl_t  sctrl;
  esc_pkg::kind_e        kinds [Depth];
  logic                  room, nonempty;

  assign in_ready_o = !out_vld_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign dec        = esc_pkg::classify(ch_i);
  assign room       = cnt_q < CntW'(Depth);
  assign nonempty   = cnt_q != '0;

  assign sctrl.push = in_acc && !last_i && dec.cls == esc_pkg::CLS_OPEN && room;
  assign sctrl.pop  = in_acc && !last_i && dec.cls == esc_pkg::CLS_CLOSE && nonempty &&
                      kinds[0] == dec.kind;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    esc_pkg::kind_e up, dn;
    if (i == 0) begin : g_top
      assign up = dec.kind;
    end else begin : g_mid
      assign up = kinds[i-1];
    end
    if (i == Depth - 1) begin : g_bot
      assign dn = esc_pkg::KIND_PAR;
    end else begin : g_lo
      assign dn = kinds[i+1];
    end
    esc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (sctrl),
      .upper_i (up),
      .lower_i (dn),
      .kind_o  (kinds[i])
    );
  end

  always_comb begin
    cnt_d      = cnt_q;
    prev_cls_d = prev_cls_q;
    prev_dot_d = prev_dot_q;
    at_start_d = at_start_q;
    failed_d   = failed_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q && !out_ready_i;

    if (in_acc) begin
      if (last_i) begin
        res_d      = !failed_q && !at_start_q && !prev_dot_q && ch_i == esc_pkg::ChHash &&
                     (prev_cls_q == esc_pkg::CLS_DIGIT || prev_cls_q == esc_pkg::CLS_CLOSE) &&
                     !nonempty;
        out_vld_d  = 1'b1;
        cnt_d      = '0;
        prev_cls_d = esc_pkg::CLS_NONE;
        prev_dot_d = 1'b0;
        at_start_d = 1'b1;
        failed_d   = 1'b0;
      end else if (!at_start_q && dec.cls == esc_pkg::CLS_DOT) begin
        // dot leaves prev_cls alone, fails unless a digit came just before, and marks that a digit must follow
        if (prev_dot_q || prev_cls_q != esc_pkg::CLS_DIGIT) failed_d = 1'b1;
        prev_dot_d = 1'b1;
      end else begin
        if (at_start_q) begin
          if (dec.cls != esc_pkg::CLS_DIGIT && dec.cls != esc_pkg::CLS_OPEN) failed_d = 1'b1;
        end else begin
          if (prev_dot_q && dec.cls != esc_pkg::CLS_DIGIT) failed_d = 1'b1;
          if (!esc_pkg::allowed_after(prev_cls_q, dec.cls)) failed_d = 1'b1;
        end
        if (dec.cls == esc_pkg::CLS_OPEN && !room) failed_d = 1'b1;
        if (dec.cls == esc_pkg::CLS_CLOSE && !sctrl.pop) failed_d = 1'b1;
        if (sctrl.push) cnt_d = cnt_q + CntW'(1);
        if (sctrl.pop)  cnt_d = cnt_q - CntW'(1);
        at_start_d = 1'b0;
        prev_cls_d = dec.cls;
        prev_dot_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      prev_cls_q <= esc_pkg::CLS_NONE;
      prev_dot_q <= 1'b0;
      at_start_q <= 1'b1;
      failed_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      prev_cls_q <= prev_cls_d;
      prev_dot_q <= prev_dot_d;
      at_start_q <= at_start_d;
      failed_q   <= failed_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign valid_res_o = res_q;

endmodule

// ===== rtl/esc_cell.sv =====
// esc_cell: one entry of the shifting bracket stack
// depends on esc_pkg; a row of these forms the stack, cell 0 is the top

module esc_cell (
  input  logic                      clk_i,
  input  esc_pkg::stack_ctrl_t      ctrl_i,
  input  esc_pkg::kind_e            upper_i,  // neighbor nearer the top, or the new opener
  input  esc_pkg::kind_e            lower_i,  // neighbor deeper in the stack
  output esc_pkg::kind_e            kind_o
);

  esc_pkg::kind_e kind_q, kind_d;

  always_comb begin
    kind_d = kind_q;
    if (ctrl_i.push) begin
      kind_d = upper_i;
    end else if (ctrl_i.pop) begin
      kind_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

// ===== rtl/esc_checker.sv =====
// esc_checker: port-level assertions for expression_syntax_checker
// depends on esc_pkg; bound to the top level at the end of this file

module esc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] ch_i,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       valid_res_o
);

  logic in_txn;
  assign in_txn = in_valid_i && in_ready_o;

  // final character yields a result transaction next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn && last_i |=> out_valid_o)
    else $error("no result after final character");

  // other characters never create a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn && !last_i && (!out_valid_o || out_ready_i) |=> !out_valid_o)
    else $error("result without final character");

  // a final character other than '#' always fails
  a_bad_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn && last_i && ch_i != esc_pkg::ChHash |=> !valid_res_o)
    else $error("expression without '#' accepted");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(valid_res_o))
    else $error("stalled result dropped or changed");

endmodule

bind expression_syntax_checker esc_checker u_esc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .ch_i        (ch_i),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .valid_res_o (valid_res_o)
);
